[sv/sts_pkg.sv]
// ----------------------------------------------------------------------------
// sts_pkg
// Shared widths, types and codes for the sphere triangle subdivider.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int COORD_WIDTH  = 20;
   localparam int FRAC_BITS    = 12;
   localparam int RADIUS_WIDTH = COORD_WIDTH - 1;
   localparam int SUM_WIDTH    = COORD_WIDTH + 1;

   // the largest normalized magnitude lives in [2^(NORM_BITS-1), 2^NORM_BITS)
   localparam int NORM_BITS  = 21;
   localparam int MAG_WIDTH  = (SUM_WIDTH > NORM_BITS) ? SUM_WIDTH : NORM_BITS + 1;
   localparam int SQ_WIDTH   = 2 * NORM_BITS + 2;
   localparam int LEN_SHIFT  = 20;
   localparam int RAD_WIDTH  = SQ_WIDTH + LEN_SHIFT;
   localparam int ROOT_WIDTH = RAD_WIDTH / 2;
   localparam int REM_WIDTH  = ROOT_WIDTH + 1;
   localparam int NUM_SHIFT  = 10;
   localparam int PROD_WIDTH = NORM_BITS + RADIUS_WIDTH;
   localparam int DVD_WIDTH  = PROD_WIDTH + NUM_SHIFT + 2;
   localparam int DVS_WIDTH  = ROOT_WIDTH + 1;
   localparam int QUO_WIDTH  = COORD_WIDTH + 1;
   localparam int STEP_WIDTH = $clog2((ROOT_WIDTH > QUO_WIDTH) ? ROOT_WIDTH : QUO_WIDTH);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic [RADIUS_WIDTH-1:0]       radius_type;

   localparam radius_type RADIUS_RESET = RADIUS_WIDTH'(1 << FRAC_BITS);
   localparam coord_type  COORD_MAX    = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam coord_type  COORD_MIN    = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec_type;

   typedef struct packed {
      sum_type x;
      sum_type y;
      sum_type z;
   } svec_type;

   typedef struct packed {
      logic ab;
      logic ac;
      logic bc;
   } edge_zero_type;

   typedef struct packed {
      vec_type       a;
      vec_type       b;
      vec_type       c;
      svec_type      s_ab;
      svec_type      s_ac;
      svec_type      s_bc;
      edge_zero_type zero;
   } entry_type;

   typedef struct packed {
      vec_type a;
      vec_type b;
      vec_type c;
      vec_type m_ab;
      vec_type m_ac;
      vec_type m_bc;
   } rec_type;

   typedef struct packed {
      logic start;
      logic zero;
   } mid_ctrl_type;

   typedef struct packed {
      logic done;
   } mid_stat_type;

   typedef enum logic [1:0] {SEQ_IDLE, SEQ_START, SEQ_WAIT, SEQ_HAND} seq_state_type;

   typedef enum logic [2:0] {
      MID_IDLE, MID_NORM, MID_SQ, MID_ROOT, MID_PREP, MID_DIV, MID_SAT, MID_DONE
   } mid_state_type;

   typedef enum logic [1:0] {BEAT_A, BEAT_B, BEAT_C, BEAT_MID} beat_type;

   typedef enum logic [1:0] {EDGE_AB, EDGE_AC, EDGE_BC} edge_type;

endpackage

[sv/sts_front.sv]
// ----------------------------------------------------------------------------
// sts_front
// Request stage: takes a triangle, forms the edge sums a+b, a+c and b+c,
// flags the edges whose sum is zero, then pushes the entry into the queue.
// ----------------------------------------------------------------------------
module sts_front
   import sts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  vec_type   vert_a,
   input  vec_type   vert_b,
   input  vec_type   vert_c,
   input  logic      q_full,
   output logic      push,
   output entry_type entry
);

   logic      valid_ff, valid_in;
   entry_type entry_ff, entry_in;
   logic      accept;

   function automatic svec_type add_vec(vec_type u, vec_type v);
      svec_type s;
      s.x = sum_type'(u.x) + sum_type'(v.x);
      s.y = sum_type'(u.y) + sum_type'(v.y);
      s.z = sum_type'(u.z) + sum_type'(v.z);
      return s;
   endfunction

   assign req_stall = valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !q_full;
   assign entry     = entry_ff;
   assign valid_in  = accept || (valid_ff && !push);

   always_comb begin
      entry_in.a       = vert_a;
      entry_in.b       = vert_b;
      entry_in.c       = vert_c;
      entry_in.s_ab    = add_vec(vert_a, vert_b);
      entry_in.s_ac    = add_vec(vert_a, vert_c);
      entry_in.s_bc    = add_vec(vert_b, vert_c);
      entry_in.zero.ab = (entry_in.s_ab == '0);
      entry_in.zero.ac = (entry_in.s_ac == '0);
      entry_in.zero.bc = (entry_in.s_bc == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

endmodule

[sv/sts_queue.sv]
// ----------------------------------------------------------------------------
// sts_queue
// Short queue between the request stage and the midpoint sequencer.
// ----------------------------------------------------------------------------
module sts_queue
   import sts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output logic      full,
   output logic      not_empty,
   output entry_type head
);

   entry_type               slot_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff;
   logic [QCNT_WIDTH-1:0]   count_ff;

   assign full      = (count_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

endmodule

[sv/sts_mid.sv]
// ----------------------------------------------------------------------------
// sts_mid
// Midpoint engine: normalizes an edge sum, accumulates the squared length,
// takes an iterative square root and divides each component, scaled by the
// radius, by it, one quotient bit per cycle in three parallel dividers.
// ----------------------------------------------------------------------------
module sts_mid
   import sts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  mid_ctrl_type ctrl,
   input  svec_type     sum,
   input  radius_type   radius,
   output mid_stat_type stat,
   output vec_type      result
);

   localparam logic [QUO_WIDTH-1:0] NEG_LIMIT = QUO_WIDTH'(1) << (COORD_WIDTH - 1);
   localparam logic [QUO_WIDTH-1:0] POS_LIMIT = NEG_LIMIT - 1'b1;

   mid_state_type             state_ff, state_in;
   logic [MAG_WIDTH-1:0]      mag_ff  [3];
   logic                      neg_ff  [3];
   logic [PROD_WIDTH-1:0]     prod_ff [3];
   logic [DVS_WIDTH-1:0]      drem_ff [3];
   logic [QUO_WIDTH-1:0]      dlo_ff  [3];
   logic [QUO_WIDTH-1:0]      quo_ff  [3];
   logic [SQ_WIDTH-1:0]       q_ff;
   logic [RAD_WIDTH-1:0]      rad_ff;
   logic [REM_WIDTH-1:0]      rem_ff;
   logic [ROOT_WIDTH-1:0]     root_ff;
   logic [STEP_WIDTH-1:0]     step_ff;
   vec_type                   res_ff;

   logic                      over, under;
   logic [1:0]                sq_idx;
   logic [NORM_BITS-1:0]      sq_mag;
   logic [SQ_WIDTH-1:0]       q_next;
   logic [REM_WIDTH+1:0]      rt_shift, rt_trial;
   logic [DVS_WIDTH-1:0]      divisor;
   logic [DVD_WIDTH-1:0]      dvd    [3];
   logic [DVS_WIDTH:0]        dv_shift [3];
   logic                      dv_ge  [3];
   sum_type                   sum_c  [3];

   function automatic logic [MAG_WIDTH-1:0] abs_mag(sum_type s);
      logic signed [MAG_WIDTH-1:0] sx;
      sx = MAG_WIDTH'(s);
      return (s < 0) ? -sx : sx;
   endfunction

   function automatic coord_type sat(logic [QUO_WIDTH-1:0] r, logic n);
      coord_type v;
      if (n) begin
         v = (r > NEG_LIMIT) ? COORD_MIN
                             : coord_type'(~r[COORD_WIDTH-1:0] + COORD_WIDTH'(1));
      end else begin
         v = (r > POS_LIMIT) ? COORD_MAX : coord_type'(r[COORD_WIDTH-1:0]);
      end
      return v;
   endfunction

   assign sum_c[0] = sum.x;
   assign sum_c[1] = sum.y;
   assign sum_c[2] = sum.z;

   assign over  = (|mag_ff[0][MAG_WIDTH-1:NORM_BITS]) || (|mag_ff[1][MAG_WIDTH-1:NORM_BITS])
               || (|mag_ff[2][MAG_WIDTH-1:NORM_BITS]);
   assign under = !over && !(mag_ff[0][NORM_BITS-1] || mag_ff[1][NORM_BITS-1]
                          || mag_ff[2][NORM_BITS-1]);

   assign sq_idx  = step_ff[1:0];
   assign sq_mag  = mag_ff[sq_idx][NORM_BITS-1:0];
   assign q_next  = q_ff + SQ_WIDTH'(sq_mag * sq_mag);

   // one root bit per cycle, two radicand bits shifted in
   assign rt_shift = {rem_ff, rad_ff[RAD_WIDTH-1 -: 2]};
   assign rt_trial = (REM_WIDTH+2)'({root_ff, 2'b01});

   // rounding: (2*num + len) / (2*len)
   assign divisor = {root_ff, 1'b0};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dvd[i]      = DVD_WIDTH'({prod_ff[i], {(NUM_SHIFT+1){1'b0}}})
                     + DVD_WIDTH'(root_ff);
         dv_shift[i] = {drem_ff[i], dlo_ff[i][QUO_WIDTH-1]};
         dv_ge[i]    = (dv_shift[i] >= {1'b0, divisor});
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MID_IDLE: begin
            if (ctrl.start) begin
               state_in = ctrl.zero ? MID_DONE : MID_NORM;
            end
         end
         MID_NORM: begin
            if (!over && !under) begin
               state_in = MID_SQ;
            end
         end
         MID_SQ: begin
            if (step_ff == STEP_WIDTH'(2)) begin
               state_in = MID_ROOT;
            end
         end
         MID_ROOT: begin
            if (step_ff == '0) begin
               state_in = MID_PREP;
            end
         end
         MID_PREP: state_in = MID_DIV;
         MID_DIV: begin
            if (step_ff == '0) begin
               state_in = MID_SAT;
            end
         end
         MID_SAT:  state_in = MID_DONE;
         MID_DONE: state_in = MID_IDLE;
         default:  state_in = MID_IDLE;
      endcase
   end

   always_comb begin
      stat.done = (state_ff == MID_DONE);
      result    = res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MID_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         MID_IDLE: begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= abs_mag(sum_c[i]);
               neg_ff[i] <= (sum_c[i] < 0);
            end
            q_ff    <= '0;
            step_ff <= '0;
            res_ff  <= '0;
         end
         MID_NORM: begin
            for (int i = 0; i < 3; i++) begin
               if (over) begin
                  mag_ff[i] <= mag_ff[i] >> 1;
               end else if (under) begin
                  mag_ff[i] <= mag_ff[i] << 1;
               end
            end
         end
         MID_SQ: begin
            q_ff            <= q_next;
            prod_ff[sq_idx] <= sq_mag * radius;
            if (step_ff == STEP_WIDTH'(2)) begin
               rad_ff  <= {q_next, {LEN_SHIFT{1'b0}}};
               rem_ff  <= '0;
               root_ff <= '0;
               step_ff <= STEP_WIDTH'(ROOT_WIDTH - 1);
            end else begin
               step_ff <= step_ff + 1'b1;
            end
         end
         MID_ROOT: begin
            rad_ff  <= rad_ff << 2;
            step_ff <= step_ff - 1'b1;
            if (rt_shift >= rt_trial) begin
               rem_ff  <= REM_WIDTH'(rt_shift - rt_trial);
               root_ff <= {root_ff[ROOT_WIDTH-2:0], 1'b1};
            end else begin
               rem_ff  <= REM_WIDTH'(rt_shift);
               root_ff <= {root_ff[ROOT_WIDTH-2:0], 1'b0};
            end
         end
         MID_PREP: begin
            for (int i = 0; i < 3; i++) begin
               drem_ff[i] <= DVS_WIDTH'(dvd[i][DVD_WIDTH-1:QUO_WIDTH]);
               dlo_ff[i]  <= dvd[i][QUO_WIDTH-1:0];
               quo_ff[i]  <= '0;
            end
            step_ff <= STEP_WIDTH'(QUO_WIDTH - 1);
         end
         MID_DIV: begin
            for (int i = 0; i < 3; i++) begin
               dlo_ff[i] <= dlo_ff[i] << 1;
               if (dv_ge[i]) begin
                  drem_ff[i] <= DVS_WIDTH'(dv_shift[i] - {1'b0, divisor});
                  quo_ff[i]  <= {quo_ff[i][QUO_WIDTH-2:0], 1'b1};
               end else begin
                  drem_ff[i] <= DVS_WIDTH'(dv_shift[i]);
                  quo_ff[i]  <= {quo_ff[i][QUO_WIDTH-2:0], 1'b0};
               end
            end
            step_ff <= step_ff - 1'b1;
         end
         MID_SAT: begin
            res_ff.x <= sat(quo_ff[0], neg_ff[0]);
            res_ff.y <= sat(quo_ff[1], neg_ff[1]);
            res_ff.z <= sat(quo_ff[2], neg_ff[2]);
         end
         default: begin
         end
      endcase
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> (state_ff == MID_IDLE))
      else $error("midpoint started while busy");

   a_normalized: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MID_SQ) |-> (!over && !under))
      else $error("squares taken on unnormalized sum");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MID_PREP) |-> (root_ff[ROOT_WIDTH-1:ROOT_WIDTH-2] != 2'b00))
      else $error("length below lower bound");

endmodule

[sv/sts_back.sv]
// ----------------------------------------------------------------------------
// sts_back
// Back end: pulls queued triangles, runs edges ab, ac and bc in turn through
// the midpoint engine and hands the finished set to the response stage,
// which sends the sub-triangles at corners a, b and c and the middle one.
// ----------------------------------------------------------------------------
module sts_back
   import sts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  entry_type  head,
   output logic       pop,
   input  radius_type radius,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output vec_type    out_first,
   output vec_type    out_second,
   output vec_type    out_third,
   output logic       out_last
);

   seq_state_type seq_ff, seq_in;
   edge_type      edge_ff;
   entry_type     work_ff;
   vec_type       m_ab_ff, m_ac_ff, m_bc_ff;
   logic          busy_ff;
   beat_type      beat_ff;
   rec_type       rec_ff;

   mid_ctrl_type  mid_ctrl;
   mid_stat_type  mid_stat;
   svec_type      mid_sum;
   vec_type       mid_result;
   logic          emit_free;
   logic          load_rec;
   logic          rsp_take;

   sts_mid u_mid (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mid_ctrl),
      .sum    (mid_sum),
      .radius (radius),
      .stat   (mid_stat),
      .result (mid_result)
   );

   assign rsp_take  = busy_ff && !rsp_stall;
   assign emit_free = !busy_ff || (beat_ff == BEAT_MID && !rsp_stall);
   assign rsp_valid = busy_ff;

   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SEQ_IDLE: begin
            if (q_valid) begin
               seq_in = SEQ_START;
            end
         end
         SEQ_START: seq_in = SEQ_WAIT;
         SEQ_WAIT: begin
            if (mid_stat.done) begin
               seq_in = (edge_ff == EDGE_BC) ? SEQ_HAND : SEQ_START;
            end
         end
         SEQ_HAND: begin
            if (emit_free) begin
               seq_in = SEQ_IDLE;
            end
         end
         default: seq_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      pop            = (seq_ff == SEQ_IDLE) && q_valid;
      load_rec       = (seq_ff == SEQ_HAND) && emit_free;
      mid_ctrl.start = (seq_ff == SEQ_START);
      case (edge_ff)
         EDGE_AB: begin
            mid_sum       = work_ff.s_ab;
            mid_ctrl.zero = work_ff.zero.ab;
         end
         EDGE_AC: begin
            mid_sum       = work_ff.s_ac;
            mid_ctrl.zero = work_ff.zero.ac;
         end
         default: begin
            mid_sum       = work_ff.s_bc;
            mid_ctrl.zero = work_ff.zero.bc;
         end
      endcase
   end

   always_comb begin
      out_last = 1'b0;
      case (beat_ff)
         BEAT_A: begin
            out_first  = rec_ff.a;
            out_second = rec_ff.m_ab;
            out_third  = rec_ff.m_ac;
         end
         BEAT_B: begin
            out_first  = rec_ff.b;
            out_second = rec_ff.m_bc;
            out_third  = rec_ff.m_ab;
         end
         BEAT_C: begin
            out_first  = rec_ff.c;
            out_second = rec_ff.m_ac;
            out_third  = rec_ff.m_bc;
         end
         default: begin
            out_first  = rec_ff.m_ab;
            out_second = rec_ff.m_bc;
            out_third  = rec_ff.m_ac;
            out_last   = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff  <= SEQ_IDLE;
         edge_ff <= EDGE_AB;
         busy_ff <= 1'b0;
         beat_ff <= BEAT_A;
      end else begin
         seq_ff <= seq_in;
         if (pop) begin
            edge_ff <= EDGE_AB;
         end else if (seq_ff == SEQ_WAIT && mid_stat.done) begin
            case (edge_ff)
               EDGE_AB: edge_ff <= EDGE_AC;
               EDGE_AC: edge_ff <= EDGE_BC;
               default: edge_ff <= EDGE_BC;
            endcase
         end
         if (load_rec) begin
            busy_ff <= 1'b1;
            beat_ff <= BEAT_A;
         end else if (rsp_take) begin
            case (beat_ff)
               BEAT_A:  beat_ff <= BEAT_B;
               BEAT_B:  beat_ff <= BEAT_C;
               BEAT_C:  beat_ff <= BEAT_MID;
               default: busy_ff <= 1'b0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         work_ff <= head;
      end
      if (seq_ff == SEQ_WAIT && mid_stat.done) begin
         case (edge_ff)
            EDGE_AB: m_ab_ff <= mid_result;
            EDGE_AC: m_ac_ff <= mid_result;
            default: m_bc_ff <= mid_result;
         endcase
      end
      if (load_rec) begin
         rec_ff.a    <= work_ff.a;
         rec_ff.b    <= work_ff.b;
         rec_ff.c    <= work_ff.c;
         rec_ff.m_ab <= m_ab_ff;
         rec_ff.m_ac <= m_ac_ff;
         rec_ff.m_bc <= m_bc_ff;
      end
   end

   a_hand_off: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SEQ_HAND && emit_free) |=> (rsp_valid && beat_ff == BEAT_A))
      else $error("finished triangle not presented");

endmodule

[sv/sphere_triangle_subdivider.sv]
// ----------------------------------------------------------------------------
// sphere_triangle_subdivider
// One icosphere refinement step: a triangle in, four sub-triangles out, with
// the edge midpoints projected onto a sphere of programmable radius.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   three vertices, x/y/z each
//   rsp      out        rsp_valid/rsp_stall   three corners, last_of_four
//   csr      in         csr_valid/csr_ready   radius (csr_data)
//
// Each midpoint runs start, normalize, squaring, a bit-serial square root,
// a divide set-up, a bit-serial divide, saturate and done; a zero-length
// edge goes from start straight to done. The back end also passes through
// its pop and hand-off states, and pops a new triangle only after handing
// off the current one. The request stage and a two-entry queue take new
// triangles while one is in work and the previous one is still being sent;
// four responses follow back to back unless rsp_stall holds them.
// Synchronous active-high reset; radius resets to 1.0.
// ----------------------------------------------------------------------------
module sphere_triangle_subdivider
   import sts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  coord_type  req_vertex_a_x,
   input  coord_type  req_vertex_a_y,
   input  coord_type  req_vertex_a_z,
   input  coord_type  req_vertex_b_x,
   input  coord_type  req_vertex_b_y,
   input  coord_type  req_vertex_b_z,
   input  coord_type  req_vertex_c_x,
   input  coord_type  req_vertex_c_y,
   input  coord_type  req_vertex_c_z,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output coord_type  rsp_first_x,
   output coord_type  rsp_first_y,
   output coord_type  rsp_first_z,
   output coord_type  rsp_second_x,
   output coord_type  rsp_second_y,
   output coord_type  rsp_second_z,
   output coord_type  rsp_third_x,
   output coord_type  rsp_third_y,
   output coord_type  rsp_third_z,
   output logic       rsp_last_of_four,

   input  logic       csr_valid,
   output logic       csr_ready,
   input  radius_type csr_data
);

   radius_type radius_ff;
   vec_type    vert_a, vert_b, vert_c;
   vec_type    out_first, out_second, out_third;
   logic       q_full, q_push, q_pop, q_valid;
   entry_type  front_entry, q_head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_data;
      end
   end

   assign vert_a = '{x: req_vertex_a_x, y: req_vertex_a_y, z: req_vertex_a_z};
   assign vert_b = '{x: req_vertex_b_x, y: req_vertex_b_y, z: req_vertex_b_z};
   assign vert_c = '{x: req_vertex_c_x, y: req_vertex_c_y, z: req_vertex_c_z};

   sts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .vert_a    (vert_a),
      .vert_b    (vert_b),
      .vert_c    (vert_c),
      .q_full    (q_full),
      .push      (q_push),
      .entry     (front_entry)
   );

   sts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_entry),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (q_head)
   );

   sts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .head       (q_head),
      .pop        (q_pop),
      .radius     (radius_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .out_first  (out_first),
      .out_second (out_second),
      .out_third  (out_third),
      .out_last   (rsp_last_of_four)
   );

   assign rsp_first_x  = out_first.x;
   assign rsp_first_y  = out_first.y;
   assign rsp_first_z  = out_first.z;
   assign rsp_second_x = out_second.x;
   assign rsp_second_y = out_second.y;
   assign rsp_second_z = out_second.z;
   assign rsp_third_x  = out_third.x;
   assign rsp_third_y  = out_third.y;
   assign rsp_third_z  = out_third.z;

endmodule
